// ===== design/blt_pkg.sv =====
package blt_pkg;

    localparam int DIM_W      = 13;
    localparam int BPP_W      = 3;
    localparam int PIX_W      = 32;
    localparam int OFF_W      = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BPP         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_LEFT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_TOP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_ZERO   = 3'd7;

    // reset values
    localparam logic [DIM_W-1:0] RST_DEST_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RST_DEST_HEIGHT = 13'd480;
    localparam logic [BPP_W-1:0] RST_BPP         = 3'd4;
    localparam logic [DIM_W-1:0] RST_SRC_WIDTH   = 13'd16;
    localparam logic [DIM_W-1:0] RST_SRC_HEIGHT  = 13'd16;

    localparam logic [PIX_W-1:0] KEY_COLOR = 32'h0000_0000;

    typedef struct packed {
        logic [DIM_W-1:0]        dest_width;
        logic [DIM_W-1:0]        dest_height;
        logic [BPP_W-1:0]        bytes_per_pixel;
        logic signed [DIM_W-1:0] origin_left;
        logic signed [DIM_W-1:0] origin_top;
        logic [DIM_W-1:0]        src_width;
        logic [DIM_W-1:0]        src_height;
        logic                    skip_zero;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic clip;
        logic mul;
        logic load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic keep;
        logic out_free;
    } sts_t;

endpackage

// ===== design/blt_ifs.sv =====
interface blt_pix_if;
    logic                         valid;
    logic                         ready;
    logic [blt_pkg::PIX_W-1:0]    src_pixel;

    modport source (output valid, output src_pixel, input ready);
    modport sink   (input valid, input src_pixel, output ready);
endinterface

interface blt_wr_if;
    logic                         valid;
    logic                         ready;
    logic [blt_pkg::OFF_W-1:0]    write_offset;
    logic [blt_pkg::PIX_W-1:0]    write_color;
    logic                         frame_done;

    modport source (output valid, output write_offset, output write_color,
                    output frame_done, input ready);
    modport sink   (input valid, input write_offset, input write_color,
                    input frame_done, output ready);
endinterface

interface blt_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [blt_pkg::CFG_IDX_W-1:0]  index;
    logic [blt_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/blt_cfg.sv =====
module blt_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_valid,
    output logic                           wr_ready,
    input  logic [blt_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [blt_pkg::CFG_DATA_W-1:0] wr_data,
    output blt_pkg::cfg_t                  cfg
);

    blt_pkg::cfg_t cfg_reg;
    blt_pkg::cfg_t cfg_next;

    assign wr_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_valid)
        begin
            unique case (wr_index)
                blt_pkg::REG_DEST_WIDTH:  cfg_next.dest_width = wr_data[blt_pkg::DIM_W-1:0];
                blt_pkg::REG_DEST_HEIGHT: cfg_next.dest_height = wr_data[blt_pkg::DIM_W-1:0];
                blt_pkg::REG_BPP:         cfg_next.bytes_per_pixel = wr_data[blt_pkg::BPP_W-1:0];
                blt_pkg::REG_ORIGIN_LEFT: cfg_next.origin_left = wr_data[blt_pkg::DIM_W-1:0];
                blt_pkg::REG_ORIGIN_TOP:  cfg_next.origin_top = wr_data[blt_pkg::DIM_W-1:0];
                blt_pkg::REG_SRC_WIDTH:   cfg_next.src_width = wr_data[blt_pkg::DIM_W-1:0];
                blt_pkg::REG_SRC_HEIGHT:  cfg_next.src_height = wr_data[blt_pkg::DIM_W-1:0];
                blt_pkg::REG_SKIP_ZERO:   cfg_next.skip_zero = wr_data[0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_width      <= blt_pkg::RST_DEST_WIDTH;
            cfg_reg.dest_height     <= blt_pkg::RST_DEST_HEIGHT;
            cfg_reg.bytes_per_pixel <= blt_pkg::RST_BPP;
            cfg_reg.origin_left     <= '0;
            cfg_reg.origin_top      <= '0;
            cfg_reg.src_width       <= blt_pkg::RST_SRC_WIDTH;
            cfg_reg.src_height      <= blt_pkg::RST_SRC_HEIGHT;
            cfg_reg.skip_zero       <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/blt_ctrl.sv =====
module blt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  blt_pkg::sts_t sts,
    output blt_pkg::cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLIP  = 2'd1;
    localparam logic [1:0] ST_MUL   = 2'd2;
    localparam logic [1:0] ST_SCALE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.take = in_valid;
                if (in_valid)
                    state_next = ST_CLIP;
            end
            ST_CLIP:
            begin
                cmd.clip   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                // clipped or keyed pixel ends here
                cmd.mul    = sts.keep;
                state_next = sts.keep ? ST_SCALE : ST_IDLE;
            end
            ST_SCALE:
            begin
                cmd.load = sts.out_free;
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== design/blt_dp.sv =====
module blt_dp #(
    parameter int MAX_DIM = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  blt_pkg::cfg_t               cfg,
    input  blt_pkg::cmd_t               cmd,
    output blt_pkg::sts_t               sts,
    input  logic [blt_pkg::PIX_W-1:0]   src_pixel,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [blt_pkg::OFF_W-1:0]   out_offset,
    output logic [blt_pkg::PIX_W-1:0]   out_color,
    output logic                        out_frame_done
);

    localparam int DW = blt_pkg::DIM_W;
    localparam int PW = $clog2(MAX_DIM);
    localparam int SW = PW + 1;
    localparam int EW = (SW > DW) ? SW : DW;
    localparam int XW = ((PW + 1 > DW) ? PW + 1 : DW) + 1;
    localparam int OW = blt_pkg::OFF_W;

    // source position
    logic [PW-1:0] col_reg, col_next;
    logic [PW-1:0] row_reg, row_next;

    // pixel being worked on
    logic [PW-1:0]               colc_reg, rowc_reg;
    logic [blt_pkg::PIX_W-1:0]   color_reg;
    logic                        last_reg;
    logic                        keep_reg;
    logic [DW-1:0]               x_reg, y_reg;
    logic [OW-1:0]               prod_reg;

    // result register
    logic                        out_valid_reg;
    logic [OW-1:0]               out_offset_reg;
    logic [blt_pkg::PIX_W-1:0]   out_color_reg;
    logic                        out_frame_reg;

    logic [EW-1:0] sw_ext, sh_ext;
    logic [SW-1:0] sw, sh;
    logic [PW-1:0] colc, rowc;
    logic [SW-1:0] col_inc, row_inc;
    logic          last_col, last_row;

    logic signed [XW-1:0] x_s, y_s;
    logic                 keep;
    logic [OW-1:0]        pix_idx;
    logic [OW-1:0]        offset;

    // source size with zero as one and large values held at the maximum
    always_comb
    begin
        sw_ext = EW'(cfg.src_width);
        sh_ext = EW'(cfg.src_height);
        if (sw_ext == '0)
            sw_ext = EW'(1);
        else if (sw_ext > EW'(MAX_DIM))
            sw_ext = EW'(MAX_DIM);
        if (sh_ext == '0)
            sh_ext = EW'(1);
        else if (sh_ext > EW'(MAX_DIM))
            sh_ext = EW'(MAX_DIM);
        sw = sw_ext[SW-1:0];
        sh = sh_ext[SW-1:0];
    end

    // position step, held inside a source size that may have shrunk
    always_comb
    begin
        colc = ({1'b0, col_reg} >= sw) ? PW'(sw - SW'(1)) : col_reg;
        rowc = ({1'b0, row_reg} >= sh) ? PW'(sh - SW'(1)) : row_reg;
        col_inc  = {1'b0, colc} + SW'(1);
        row_inc  = {1'b0, rowc} + SW'(1);
        last_col = (col_inc >= sw);
        last_row = (row_inc >= sh);
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_inc[PW-1:0];
        end
        else
        begin
            col_next = col_inc[PW-1:0];
            row_next = rowc;
        end
    end

    // destination point and clipping
    always_comb
    begin
        x_s  = XW'(cfg.origin_left) + $signed(XW'(colc_reg));
        y_s  = XW'(cfg.origin_top) + $signed(XW'(rowc_reg));
        keep = !x_s[XW-1] && !y_s[XW-1]
            && (x_s < $signed(XW'(cfg.dest_width)))
            && (y_s < $signed(XW'(cfg.dest_height)))
            && !(cfg.skip_zero && (color_reg == blt_pkg::KEY_COLOR));
    end

    assign pix_idx = prod_reg + OW'(x_reg);
    assign offset  = OW'(pix_idx * OW'(cfg.bytes_per_pixel));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.take)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            colc_reg  <= colc;
            rowc_reg  <= rowc;
            color_reg <= src_pixel;
            last_reg  <= last_col && last_row;
        end
        if (cmd.clip)
        begin
            keep_reg <= keep;
            x_reg    <= x_s[DW-1:0];
            y_reg    <= y_s[DW-1:0];
        end
        if (cmd.mul)
            prod_reg <= OW'(y_reg * cfg.dest_width);
        if (cmd.load)
        begin
            out_offset_reg <= offset;
            out_color_reg  <= color_reg;
            out_frame_reg  <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign sts.keep     = keep_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign out_offset     = out_offset_reg;
    assign out_color      = out_color_reg;
    assign out_frame_done = out_frame_reg;

endmodule

// ===== design/color_keyed_clipped_blitter.sv =====
// a pixel is captured in idle, then goes through the clip, multiply and scale states;
//   a clipped or keyed pixel ends after multiply with no write beat, and scale
//   waits for a free output; a new pixel is taken only back in idle
// the write beat sits in an output register, so the next pixel is taken while it waits
// reset (rst_n low, asynchronous): registers return to their defaults, position to zero
module color_keyed_clipped_blitter #(
    parameter int MAX_DIM = 4096
) (
    input  logic      clk,
    input  logic      rst_n,
    blt_pix_if.sink   pix,
    blt_wr_if.source  wr,
    blt_cfg_if.sink   cfg
);

    blt_pkg::cfg_t cfg_q;
    blt_pkg::cmd_t cmd;
    blt_pkg::sts_t sts;

    // configuration registers, always ready
    blt_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_ready (cfg.ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    // sequencer: idle, clip, multiply, scale
    blt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix.valid),
        .in_ready (pix.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // position tracking, clipping, offset arithmetic and write register
    blt_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_q),
        .cmd            (cmd),
        .sts            (sts),
        .src_pixel      (pix.src_pixel),
        .out_valid      (wr.valid),
        .out_ready      (wr.ready),
        .out_offset     (wr.write_offset),
        .out_color      (wr.write_color),
        .out_frame_done (wr.frame_done)
    );

endmodule

// ===== dv/blt_write_checker.sv =====
// watches the pixel, config and write channels of the blitter, keeps its own
// copy of the registers and raster position, and scores every write beat
module blt_write_checker
    import blt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    blt_pix_if   pix,
    blt_wr_if    wr,
    blt_cfg_if   cfg,
    output int   mismatches,
    output int   pending
);

    localparam int MAX_DIM = 4096;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [PIX_W-1:0] color;
        logic             done;
    } fb_write_t;

    cfg_t        regs;
    logic [11:0] column_at;
    logic [11:0] row_at;
    fb_write_t   pending_writes[$];

    // source size as the raster uses it: zero acts as one, oversize is capped
    function automatic int unsigned span_clip(input logic [DIM_W-1:0] n);
        if (n == '0)
            return 1;
        if (n > MAX_DIM)
            return MAX_DIM;
        return n;
    endfunction

    // maps one source pixel onto the destination; returns 1 when it is written
    function automatic bit place_pixel(
        input  logic [PIX_W-1:0] color,
        input  int unsigned      col_in,
        input  int unsigned      row_in,
        output fb_write_t        fb,
        output int unsigned      col_nx,
        output int unsigned      row_nx
    );
        int unsigned sw;
        int unsigned sh;
        int unsigned col;
        int unsigned row;
        bit          last_col;
        bit          last_row;
        bit          keep;
        longint      x;
        longint      y;
        longint      byte_off;
        sw  = span_clip(regs.src_width);
        sh  = span_clip(regs.src_height);
        col = (col_in >= sw) ? sw - 1 : col_in;
        row = (row_in >= sh) ? sh - 1 : row_in;
        last_col = (col + 1 >= sw);
        last_row = (row + 1 >= sh);
        x = longint'($signed(regs.origin_left)) + longint'(col);
        y = longint'($signed(regs.origin_top)) + longint'(row);
        keep = !(x < 0 || y < 0 || x >= longint'(regs.dest_width)
                 || y >= longint'(regs.dest_height));
        if (regs.skip_zero && color == KEY_COLOR)
            keep = 1'b0;
        if (last_col) begin
            col_nx = 0;
            row_nx = last_row ? 0 : row + 1;
        end
        else begin
            col_nx = col + 1;
            row_nx = row;
        end
        byte_off  = (y * longint'(regs.dest_width) + x) * longint'(regs.bytes_per_pixel);
        fb.offset = byte_off[OFF_W-1:0];
        fb.color  = color;
        fb.done   = last_col && last_row;
        return keep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fb_write_t   fb;
        int unsigned col_nx;
        int unsigned row_nx;
        if (!rst_n) begin
            regs.dest_width      = RST_DEST_WIDTH;
            regs.dest_height     = RST_DEST_HEIGHT;
            regs.bytes_per_pixel = RST_BPP;
            regs.origin_left     = '0;
            regs.origin_top      = '0;
            regs.src_width       = RST_SRC_WIDTH;
            regs.src_height      = RST_SRC_HEIGHT;
            regs.skip_zero       = 1'b0;
            column_at  = '0;
            row_at     = '0;
            pending_writes.delete();
            mismatches = 0;
            pending    = 0;
        end
        else begin
            if (wr.valid && wr.ready) begin
                if (pending_writes.size() == 0) begin
                    $display("%0t unexpected write beat: expected none, got offset %h color %h done %b",
                             $time, wr.write_offset, wr.write_color, wr.frame_done);
                    mismatches = mismatches + 1;
                end
                else begin
                    fb = pending_writes.pop_front();
                    if (wr.write_offset !== fb.offset) begin
                        $display("%0t write_offset: expected %h, got %h",
                                 $time, fb.offset, wr.write_offset);
                        mismatches = mismatches + 1;
                    end
                    if (wr.write_color !== fb.color) begin
                        $display("%0t write_color: expected %h, got %h",
                                 $time, fb.color, wr.write_color);
                        mismatches = mismatches + 1;
                    end
                    if (wr.frame_done !== fb.done) begin
                        $display("%0t frame_done: expected %b, got %b",
                                 $time, fb.done, wr.frame_done);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_DEST_WIDTH:  regs.dest_width      = cfg.data[DIM_W-1:0];
                    REG_DEST_HEIGHT: regs.dest_height     = cfg.data[DIM_W-1:0];
                    REG_BPP:         regs.bytes_per_pixel = cfg.data[BPP_W-1:0];
                    REG_ORIGIN_LEFT: regs.origin_left     = cfg.data[DIM_W-1:0];
                    REG_ORIGIN_TOP:  regs.origin_top      = cfg.data[DIM_W-1:0];
                    REG_SRC_WIDTH:   regs.src_width       = cfg.data[DIM_W-1:0];
                    REG_SRC_HEIGHT:  regs.src_height      = cfg.data[DIM_W-1:0];
                    REG_SKIP_ZERO:   regs.skip_zero       = cfg.data[0];
                    default: ;
                endcase
            end
            if (pix.valid && pix.ready) begin
                if (place_pixel(pix.src_pixel, column_at, row_at, fb, col_nx, row_nx))
                    pending_writes.push_back(fb);
                column_at = col_nx[11:0];
                row_at    = row_nx[11:0];
            end
            pending = pending_writes.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
module testbench;
    import blt_pkg::*;

    // well above the slowest legal run of about 1600 pixel beats
    localparam int LIMIT_CYCLES = 400000;
    // a full pixel slot, with margin for a clipped pixel in flight
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASES = 20;
    localparam int BEATS_PER_PHASE = 77;

    logic clk = 1'b0;
    logic rst_n;
    int   cycles = 0;
    int   mismatch_cnt;
    int   pending_cnt;
    int   send_idle_pct;
    int   recv_idle_pct;

    blt_pix_if pix_ch();
    blt_wr_if  wr_ch();
    blt_cfg_if cfg_ch();

    color_keyed_clipped_blitter DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_ch),
        .wr    (wr_ch),
        .cfg   (cfg_ch)
    );

    blt_write_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix_ch),
        .wr         (wr_ch),
        .cfg        (cfg_ch),
        .mismatches (mismatch_cnt),
        .pending    (pending_cnt)
    );

    always #10 clk = ~clk;

    // watchdog: a hung handshake or a lost write ends here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // write sink backpressure, redrawn every cycle
    always @(negedge clk)
    begin
        if (rst_n)
            wr_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // pixel beat with random idle cycles ahead of it; valid stays high on return
    task automatic send_pixel(input logic [PIX_W-1:0] color);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.src_pixel <= color;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        @(negedge clk);
    endtask

    // one register beat; the caller drops valid after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
    endtask

    // stop sending, wait for every predicted write, then let clipped pixels clear
    task automatic drain();
        pix_ch.valid <= 1'b0;
        while (pending_cnt != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // full register set; unused upper data bits carry junk the block must ignore
    task automatic program_regs(input int dw, input int dh, input int bpp, input int ol,
                                input int ot, input int sw, input int sh, input int sz);
        drain();
        write_reg(REG_DEST_WIDTH,  {3'($urandom_range(7)), 13'(dw)});
        write_reg(REG_DEST_HEIGHT, {3'($urandom_range(7)), 13'(dh)});
        write_reg(REG_BPP,         {13'($urandom), 3'(bpp)});
        write_reg(REG_ORIGIN_LEFT, {3'($urandom_range(7)), 13'(ol)});
        write_reg(REG_ORIGIN_TOP,  {3'($urandom_range(7)), 13'(ot)});
        write_reg(REG_SRC_WIDTH,   {3'($urandom_range(7)), 13'(sw)});
        write_reg(REG_SRC_HEIGHT,  {3'($urandom_range(7)), 13'(sh)});
        write_reg(REG_SKIP_ZERO,   {15'($urandom), 1'(sz)});
        cfg_ch.valid <= 1'b0;
    endtask

    // key color often enough that transparency kicks in, all-ones for the top bits
    function automatic logic [PIX_W-1:0] random_color();
        case ($urandom_range(9))
            0, 1:    return KEY_COLOR;
            2:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // mostly a small sprite around a small destination, so many frames finish
    // and writes are frequent; now and then one of the extreme corners
    task automatic pick_geometry();
        int dw;
        int dh;
        int bpp;
        int ol;
        int ot;
        int sw;
        int sh;
        sw  = $urandom_range(1, 12);
        sh  = $urandom_range(1, 8);
        dw  = $urandom_range(1, 40);
        dh  = $urandom_range(1, 30);
        ol  = int'($urandom_range(0, dw + 3)) - 4;
        ot  = int'($urandom_range(0, dh + 3)) - 4;
        bpp = ($urandom_range(4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
        case ($urandom_range(9))
            // very wide destination, origin anywhere in the signed range
            0:
            begin
                dw = $urandom_range(4096, 8191);
                ol = int'($urandom_range(0, 8191)) - 4096;
            end
            // far down a huge bitmap, offset can run past 26 bits
            1:
            begin
                dw = 8191;
                dh = 8191;
                ot = 4095 - $urandom_range(0, 8);
                ol = $urandom_range(0, 4095);
            end
            // zero source size acts as one
            2:
            begin
                sw = 0;
                sh = $urandom_range(0, 2);
            end
            // empty destination clips everything
            3:
            begin
                if ($urandom_range(1))
                    dw = 0;
                else
                    dh = 0;
            end
            // oversize source row, capped at the maximum
            4:
            begin
                sw = $urandom_range(4096, 8191);
                sh = $urandom_range(1, 3);
                ol = -int'($urandom_range(0, 40));
            end
            default: ;
        endcase
        program_regs(dw, dh, bpp, ol, ot, sw, sh, $urandom_range(1));
    endtask

    initial
    begin
        int  phase;
        int  n;
        int  base_send;
        int  base_recv;
        bit  calm;
        rst_n            = 1'b0;
        pix_ch.valid     = 1'b0;
        pix_ch.src_pixel = '0;
        wr_ch.ready      = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_DEST_WIDTH;
        cfg_ch.data      = '0;
        send_idle_pct    = 30;
        recv_idle_pct    = 54;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset geometry: key off, so a zero pixel is still written
        send_pixel(KEY_COLOR);
        send_pixel('1);
        send_pixel(32'hA5A5_A5A5);

        // 3x3 sprite hanging off the top-left corner of a 4x4 bitmap, key on:
        // left column and top row clipped, zero pixels dropped; the raster resumes
        // clamped to the last column, so the seventh pixel lands inside and carries frame_done
        program_regs(4, 4, 1, -1, -1, 3, 3, 1);
        send_pixel(32'h1111_1111);
        send_pixel(KEY_COLOR);
        send_pixel(32'h2222_2222);
        send_pixel(32'h3333_3333);
        send_pixel(32'h4444_4444);
        send_pixel(KEY_COLOR);
        send_pixel(32'h5555_5555);
        send_pixel(32'h6666_6666);
        send_pixel(32'h7777_7777);

        // zero-width destination clips every pixel
        program_regs(0, 5, 2, 0, 0, 2, 1, 0);
        send_pixel(32'h8888_8888);
        send_pixel(32'h9999_9999);

        // zero source size: every pixel is the last one; max origin and
        // max destination with 7 bytes per pixel wrap the offset
        program_regs(8191, 8191, 7, 4095, 4095, 0, 0, 0);
        send_pixel(KEY_COLOR);
        send_pixel('1);
        send_pixel(32'hDEAD_BEEF);

        // oversize source width, most negative origin, 5 bytes per pixel
        program_regs(4096, 4096, 5, -4096, 0, 8191, 1, 1);
        send_pixel(32'h0BAD_F00D);
        send_pixel(KEY_COLOR);
        send_pixel(32'hCAFE_0001);

        // random phases: receiver-heavy idling, then sender-heavy, then none
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase < 7)
            begin
                base_send = 30;
                base_recv = 54;
            end
            else if (phase < 14)
            begin
                base_send = 54;
                base_recv = 30;
            end
            else
            begin
                base_send = 0;
                base_recv = 0;
            end
            pick_geometry();
            calm = 1'b0;
            for (n = 0; n < BEATS_PER_PHASE; n++)
            begin
                // occasional stretch at full rate inside an idling phase
                if (n % 25 == 0)
                    calm = ($urandom_range(3) == 0);
                send_idle_pct = calm ? 0 : base_send;
                recv_idle_pct = calm ? 0 : base_recv;
                send_pixel(random_color());
            end
        end

        drain();
        if (mismatch_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
design/blt_pkg.sv
design/blt_ifs.sv
design/blt_cfg.sv
design/blt_ctrl.sv
design/blt_dp.sv
design/color_keyed_clipped_blitter.sv
dv/blt_write_checker.sv
dv/testbench.sv
